// ----- src/escape_time_fractal_iterator_defines.svh -----
// Assertion macros shared by the escape-time iterator checker
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define ETF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold on every clock edge outside reset
`define ETF_ASSERT_NOW(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Implication checked on every clock edge, reset included
`define ETF_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- src/etf_pkg.sv -----
// Shared constants and types of the escape-time iterator
package etf_pkg;

   // default number formats
   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 27;
   localparam int COUNT_BITS_DEF = 16;

   // iteration limit after reset
   localparam int LIMIT_RESET = 100;

   // configuration port
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_JULIA_MODE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONST_RE   = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONST_IM   = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ITER   = CSR_INDEX_BITS'(3);

   // point queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } etf_qstat_type;

endpackage

// ----- src/etf_queue.sv -----
// Small FIFO of prepared points between the front and the iteration core
module etf_queue
   import etf_pkg::*;
#(
   parameter int DATA_BITS = 4 * COORD_BITS_DEF + COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] rdata,
   output etf_qstat_type        qstat
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  fill_ff, fill_in;

   // advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata       = entry_ff[rd_ptr_ff];
   assign qstat.full  = (fill_ff == CNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (fill_ff == '0);

endmodule

// ----- src/etf_front.sv -----
// Front end: configuration registers, point acceptance and mode selection
module etf_front
   import etf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr,
   input  logic [CSR_INDEX_BITS-1:0]            csr_index,
   input  logic [CSR_DATA_BITS-1:0]             csr_wdata,
   input  logic                                 start,
   input  logic signed [COORD_BITS-1:0]         req_point_re,
   input  logic signed [COORD_BITS-1:0]         req_point_im,
   input  etf_qstat_type                        qstat,
   output logic                                 push,
   output logic [4*COORD_BITS+COUNT_BITS-1:0]   wdata
);

   logic                         mode_ff,  mode_in;
   logic signed [COORD_BITS-1:0] cre_ff,   cre_in;
   logic signed [COORD_BITS-1:0] cim_ff,   cim_in;
   logic [COUNT_BITS-1:0]        limit_ff, limit_in;

   logic signed [COORD_BITS-1:0] z_re, z_im, c_re, c_im;

   // decode register writes, drop unknown indexes
   always_comb begin
      mode_in  = mode_ff;
      cre_in   = cre_ff;
      cim_in   = cim_ff;
      limit_in = limit_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_JULIA_MODE: mode_in  = csr_wdata[0];
            CSR_CONST_RE:   cre_in   = csr_wdata[COORD_BITS-1:0];
            CSR_CONST_IM:   cim_in   = csr_wdata[COORD_BITS-1:0];
            CSR_MAX_ITER:   limit_in = csr_wdata[COUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         cre_ff   <= '0;
         cim_ff   <= '0;
         limit_ff <= COUNT_BITS'(LIMIT_RESET);
      end else begin
         mode_ff  <= mode_in;
         cre_ff   <= cre_in;
         cim_ff   <= cim_in;
         limit_ff <= limit_in;
      end
   end

   // route the point to z0 or c by mode
   always_comb begin
      if (mode_ff) begin
         z_re = req_point_re;
         z_im = req_point_im;
         c_re = cre_ff;
         c_im = cim_ff;
      end else begin
         z_re = cre_ff;
         z_im = cim_ff;
         c_re = req_point_re;
         c_im = req_point_im;
      end
   end

   // accept a point whenever the queue has room
   assign push  = start && !qstat.full;
   assign wdata = {z_re, z_im, c_re, c_im, limit_ff};

endmodule

// ----- src/etf_core.sv -----
// Back end: iterates z = z^2 + c one step per cycle and reports the count
module etf_core
   import etf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  etf_qstat_type                      qstat,
   input  logic [4*COORD_BITS+COUNT_BITS-1:0] rdata,
   output logic                               pop,
   output logic                               rsp_valid,
   output logic [COUNT_BITS-1:0]              rsp_iter_count
);

   localparam int CB = COORD_BITS;
   localparam int PW = 2 * COORD_BITS;
   localparam int CW = (COORD_BITS + 1 > FRAC_BITS + 3) ? COORD_BITS + 1 : FRAC_BITS + 3;

   localparam logic signed [CB-1:0] VMAX    = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] VMIN    = {1'b1, {(CB-1){1'b0}}};
   localparam logic [PW-1:0]        LIM_POS = {{(CB+1){1'b0}}, {(CB-1){1'b1}}};
   localparam logic [PW-1:0]        LIM_NEG = LIM_POS + 1'b1;
   localparam logic [CW-1:0]        FOUR    = {{(CW-3){1'b0}}, 3'b100} << FRAC_BITS;

   typedef enum logic [1:0] {
      CORE_IDLE = 2'b01,
      CORE_RUN  = 2'b10
   } core_state_type;

   // product shifted right with magnitude truncated, saturated to the coord range
   function automatic logic signed [CB-1:0] mul_shift(
      input logic signed [CB-1:0] a,
      input logic signed [CB-1:0] b,
      input int                   sh
   );
      logic signed [PW-1:0] prod;
      logic [PW-1:0]        mag;
      logic [PW-1:0]        q;
      logic                 neg;
      prod = a * b;
      neg  = prod[PW-1];
      mag  = neg ? PW'(-prod) : PW'(prod);
      q    = mag >> sh;
      if (!neg) begin
         return (q > LIM_POS) ? VMAX : q[CB-1:0];
      end
      return (q > LIM_NEG) ? VMIN : CB'(-q[CB-1:0]);
   endfunction

   // saturating add
   function automatic logic signed [CB-1:0] sat_add(
      input logic signed [CB-1:0] a,
      input logic signed [CB-1:0] b
   );
      logic signed [CB:0] s;
      s = {a[CB-1], a} + {b[CB-1], b};
      if (s[CB] != s[CB-1]) begin
         return s[CB] ? VMIN : VMAX;
      end
      return s[CB-1:0];
   endfunction

   core_state_type state_ff, state_in;

   logic signed [CB-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [CB-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [COUNT_BITS-1:0] limit_ff, limit_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic signed [CB-1:0]  q_x, q_y, q_cx, q_cy;
   logic [COUNT_BITS-1:0] q_limit;
   logic signed [CB-1:0]  xx, yy, xy2, nx, ny;
   logic [CW-1:0]         mag2;
   logic                  escaped, done, running;

   assign {q_x, q_y, q_cx, q_cy, q_limit} = rdata;

   // one step of the iteration on the current z
   always_comb begin
      xx      = mul_shift(x_ff, x_ff, FRAC_BITS);
      yy      = mul_shift(y_ff, y_ff, FRAC_BITS);
      xy2     = mul_shift(x_ff, y_ff, FRAC_BITS - 1);
      mag2    = CW'({1'b0, xx}) + CW'({1'b0, yy});
      escaped = (mag2 >= FOUR);
      nx      = sat_add(sat_add(xx, -yy), cx_ff);
      ny      = sat_add(xy2, cy_ff);
   end

   assign running = (state_ff == CORE_RUN);
   assign done    = running && ((count_ff == limit_ff) || escaped);
   assign pop     = !qstat.empty && ((state_ff == CORE_IDLE) || done);

   // sequence: load a point, iterate until it escapes or hits the limit
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      rsp_valid_in = done;
      rsp_count_in = count_ff;
      case (state_ff)
         CORE_IDLE: begin
            if (pop) begin
               state_in = CORE_RUN;
            end
         end
         CORE_RUN: begin
            if (done && !pop) begin
               state_in = CORE_IDLE;
            end
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
      if (pop) begin
         x_in     = q_x;
         y_in     = q_y;
         cx_in    = q_cx;
         cy_in    = q_cy;
         limit_in = q_limit;
         count_in = '0;
      end else if (running && !done) begin
         x_in     = nx;
         y_in     = ny;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CORE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the point under work and the result beat
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      limit_ff     <= limit_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_count = rsp_count_ff;

endmodule

// ----- src/escape_time_fractal_iterator.sv -----
// The iteration core does one z = z^2 + c step per cycle on the single point that it holds.
// A two-beat queue ahead of the core takes new points while one iterates; busy is high
//   while it is full. Results are single-cycle strobes and cannot be stalled.
// Reset (synchronous): queue and core empty, julia_mode 0, constants 0, max_iter 100.
module escape_time_fractal_iterator
   import etf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_point_re,
   input  logic signed [COORD_BITS-1:0] req_point_im,
   output logic                         rsp_valid,
   output logic [COUNT_BITS-1:0]        rsp_iter_count
);

   localparam int ENTRY_BITS = 4 * COORD_BITS + COUNT_BITS;

   etf_qstat_type         qstat;
   logic                  push, pop;
   logic [ENTRY_BITS-1:0] q_wdata, q_rdata;

   // registers take a write every cycle
   assign csr_ready = 1'b1;
   assign busy      = qstat.full;

   etf_front #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .start        (start),
      .req_point_re (req_point_re),
      .req_point_im (req_point_im),
      .qstat        (qstat),
      .push         (push),
      .wdata        (q_wdata)
   );

   etf_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (q_wdata),
      .pop   (pop),
      .rdata (q_rdata),
      .qstat (qstat)
   );

   etf_core #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .rdata          (q_rdata),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_iter_count (rsp_iter_count)
   );

endmodule

// ----- src/etf_checker.sv -----
// Port-level checker for the escape-time iterator, bound to the top level
`include "escape_time_fractal_iterator_defines.svh"

module etf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   logic [2:0] pend_ff, pend_in;
   logic       take;

   // track points taken but not yet answered
   assign take    = start && !busy;
   assign pend_in = 3'(pend_ff + {2'b00, take} - {2'b00, rsp_valid});

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `ETF_ASSERT_IMP(a_rsp_has_point, rsp_valid, pend_ff != 3'd0, "result with no point pending")
   `ETF_ASSERT_NOW(a_pend_bound, pend_ff <= 3'd4, "more points in flight than the block holds")
   `ETF_ASSERT_IMP(a_busy_full, busy, pend_ff >= 3'd2, "busy while the queue cannot be full")
   `ETF_ASSERT_ALWAYS(a_reset_quiet, $past(reset), !rsp_valid && !busy, "activity right after reset")

endmodule

bind escape_time_fractal_iterator etf_checker u_etf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// ----- tb/escape_count_checker.sv -----
// Checker for the escape-time iterator: mirrors its registers, predicts each count, compares
`timescale 1ns / 1ps
module escape_count_checker
   import etf_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata,
   input  logic                            start,
   input  logic                            busy,
   input  logic signed [COORD_BITS_DEF-1:0] req_point_re,
   input  logic signed [COORD_BITS_DEF-1:0] req_point_im,
   input  logic                            rsp_valid,
   input  logic [COUNT_BITS_DEF-1:0]       rsp_iter_count,
   output int                              outstanding,
   output int                              fail_count
);

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int NB = COUNT_BITS_DEF;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic [NB-1:0] count_type;

   typedef struct {
      coord_type re;
      coord_type im;
      count_type steps;
   } point_count_type;

   localparam coord_type COORD_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(CB-1){1'b0}}};
   // |z|^2 threshold, 4.0 in the coordinate format
   localparam logic [CB:0] ESCAPE_MAG_SQ = (CB+1)'(4) << FB;

   // register copies
   logic      julia_mode;
   coord_type const_re;
   coord_type const_im;
   count_type max_iter;

   point_count_type expected_counts[$];

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   // product shifted right by sh, magnitude truncated, then clipped to the coordinate range
   function automatic coord_type mul_sat(input coord_type a, input coord_type b,
                                         input int unsigned sh);
      logic [CB-1:0]   mag_a;
      logic [CB-1:0]   mag_b;
      logic [2*CB-1:0] prod;
      logic [2*CB-1:0] lim;
      logic            neg;
      neg   = a[CB-1] ^ b[CB-1];
      mag_a = a[CB-1] ? -a : a;
      mag_b = b[CB-1] ? -b : b;
      prod  = {{CB{1'b0}}, mag_a} * {{CB{1'b0}}, mag_b};
      prod  = prod >> sh;
      lim   = (2*CB)'(1) << (CB-1);
      if (!neg)
         lim = lim - 1;
      if (prod > lim)
         return neg ? COORD_MIN : COORD_MAX;
      return neg ? coord_type'(-prod[CB-1:0]) : coord_type'(prod[CB-1:0]);
   endfunction

   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      logic signed [CB:0] s;
      s = a + b;
      if (s[CB] != s[CB-1])
         return s[CB] ? COORD_MIN : COORD_MAX;
      return s[CB-1:0];
   endfunction

   // iterate z = z^2 + c until |z|^2 reaches 4 or the limit is hit
   function automatic count_type escape_steps(input coord_type pre, input coord_type pim);
      coord_type   x;
      coord_type   y;
      coord_type   cx;
      coord_type   cy;
      coord_type   xx;
      coord_type   yy;
      coord_type   nx;
      logic [CB:0] mag_sq;
      count_type   steps;
      logic        escaped;
      if (julia_mode) begin
         x  = pre;
         y  = pim;
         cx = const_re;
         cy = const_im;
      end else begin
         x  = const_re;
         y  = const_im;
         cx = pre;
         cy = pim;
      end
      steps   = '0;
      escaped = 1'b0;
      while (!escaped && steps < max_iter) begin
         xx     = mul_sat(x, x, FB);
         yy     = mul_sat(y, y, FB);
         mag_sq = {1'b0, xx} + {1'b0, yy};
         if (mag_sq >= ESCAPE_MAG_SQ) begin
            escaped = 1'b1;
         end else begin
            nx = sat_add(sat_add(xx, -yy), cx);
            y  = sat_add(mul_sat(x, y, FB - 1), cy);
            x  = nx;
            steps++;
         end
      end
      return steps;
   endfunction

   always @(posedge clock) begin : track
      point_count_type item;
      if (reset) begin
         julia_mode = 1'b0;
         const_re   = '0;
         const_im   = '0;
         max_iter   = count_type'(LIMIT_RESET);
         expected_counts.delete();
      end else begin
         // mirror register writes; unknown indexes change nothing
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_JULIA_MODE: julia_mode = csr_wdata[0];
               CSR_CONST_RE:   const_re   = csr_wdata[CB-1:0];
               CSR_CONST_IM:   const_im   = csr_wdata[CB-1:0];
               CSR_MAX_ITER:   max_iter   = csr_wdata[NB-1:0];
               default: ;
            endcase
         end
         // retire the oldest expected count
         if (rsp_valid) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("count %0d with no point outstanding",
                                         rsp_iter_count));
            end else begin
               item = expected_counts.pop_front();
               if (rsp_iter_count !== item.steps)
                  report_mismatch($sformatf("point (%0d, %0d): count %0d, want %0d",
                                            item.re, item.im, rsp_iter_count, item.steps));
            end
         end
         // predict the count of each accepted point
         if (start && !busy) begin
            item.re    = req_point_re;
            item.im    = req_point_im;
            item.steps = escape_steps(req_point_re, req_point_im);
            expected_counts.push_back(item);
         end
      end
      outstanding <= expected_counts.size();
   end

endmodule

// ----- tb/tb_escape_time_fractal_iterator.sv -----
// Testbench top for the escape-time iterator: stimulus, stall watchdog and verdict
`timescale 1ns / 1ps
module tb_escape_time_fractal_iterator;
   import etf_pkg::*;

   typedef logic signed [COORD_BITS_DEF-1:0] coord_type;
   typedef logic [COUNT_BITS_DEF-1:0] count_type;

   localparam int        ONE_FX        = 1 << FRAC_BITS_DEF;
   localparam coord_type COORD_MAX     = {1'b0, {(COORD_BITS_DEF-1){1'b1}}};
   localparam coord_type COORD_MIN     = {1'b1, {(COORD_BITS_DEF-1){1'b0}}};
   localparam count_type COUNT_MAX     = '1;
   localparam int        RANDOM_PHASES = 8;
   localparam int        PHASE_POINTS  = 50;
   localparam int        SETTLE_CYCLES = 8;
   localparam int        STALL_LIMIT   = 300000;

   logic                        clock;
   logic                        reset;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;
   logic                        start;
   logic                        busy;
   coord_type                   req_point_re;
   coord_type                   req_point_im;
   logic                        rsp_valid;
   count_type                   rsp_iter_count;
   int                          outstanding;
   int                          fail_count;
   int                          stall_cycles;
   logic                        steady;

   escape_time_fractal_iterator dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .start          (start),
      .busy           (busy),
      .req_point_re   (req_point_re),
      .req_point_im   (req_point_im),
      .rsp_valid      (rsp_valid),
      .rsp_iter_count (rsp_iter_count)
   );

   escape_count_checker count_check (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .start          (start),
      .busy           (busy),
      .req_point_re   (req_point_re),
      .req_point_im   (req_point_im),
      .rsp_valid      (rsp_valid),
      .rsp_iter_count (rsp_iter_count),
      .outstanding    (outstanding),
      .fail_count     (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // count cycles in which no beat moves on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (stall_cycles < STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   function automatic coord_type fx(input real v);
      return coord_type'($rtoi(v * real'(ONE_FX)));
   endfunction

   // mostly points near the sets, now and then any bit pattern
   function automatic coord_type rand_coord();
      if ($urandom_range(0, 6) == 0)
         return coord_type'($urandom);
      return coord_type'(int'($urandom_range(0, 5 * ONE_FX)) - 5 * ONE_FX / 2);
   endfunction

   function automatic coord_type rand_const();
      if ($urandom_range(0, 7) == 0)
         return coord_type'($urandom);
      return coord_type'(int'($urandom_range(0, 3 * ONE_FX)) - 3 * ONE_FX / 2);
   endfunction

   // hold the beat until the block takes it; leave start high for the next point
   task automatic send_point(input coord_type re, input coord_type im);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_point_re <= re;
      req_point_im <= im;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // write every register with junk above the field, sometimes an unknown index too
   task automatic configure(input logic mode, input coord_type cre, input coord_type cim,
                            input count_type limit);
      logic [CSR_DATA_BITS-1:0] junk;
      drain_results();
      junk = {$urandom, $urandom};
      write_csr(CSR_JULIA_MODE, {junk[CSR_DATA_BITS-1:1], mode});
      write_csr(CSR_CONST_RE, {junk[CSR_DATA_BITS-1:COORD_BITS_DEF], cre});
      write_csr(CSR_CONST_IM, {~junk[CSR_DATA_BITS-1:COORD_BITS_DEF], cim});
      write_csr(CSR_MAX_ITER, {junk[CSR_DATA_BITS-1:COUNT_BITS_DEF], limit});
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_INDEX_BITS'($urandom_range(CSR_MAX_ITER + 1,
                                                  (1 << CSR_INDEX_BITS) - 1)),
                   {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic      mode_pick;
      coord_type cre_pick;
      count_type limit_pick;
      reset        <= 1'b1;
      start        <= 1'b0;
      csr_valid    <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_point_re <= '0;
      req_point_im <= '0;
      steady        = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: Mandelbrot from z0 = 0, limit 100
      send_point(fx(0.0), fx(0.0));
      send_point(fx(-1.0), fx(0.0));
      send_point(fx(0.0), fx(1.0));
      send_point(fx(0.25), fx(0.0));
      send_point(fx(-2.0), fx(0.0));
      send_point(fx(2.0), fx(0.0));
      send_point(fx(-1.75), fx(0.0));
      send_point(fx(-0.75), fx(0.1));
      send_point(fx(0.3), fx(0.5));
      // saturating squares and sums
      send_point(COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MAX);
      send_point(COORD_MAX, fx(0.0));
      send_point(fx(0.0), COORD_MIN);

      // Julia set, including points already outside the radius
      configure(1'b1, fx(-0.8), fx(0.156), count_type'(LIMIT_RESET));
      send_point(fx(0.0), fx(0.0));
      send_point(fx(2.0), fx(0.0));
      send_point(fx(0.0), fx(-2.0));
      send_point(coord_type'(fx(2.0) - 1), fx(0.0));
      send_point(fx(1.5), fx(1.5));
      send_point(COORD_MIN, COORD_MIN);
      send_point(fx(0.3), fx(-0.2));

      // zero limit gives zero for any point
      configure(1'b1, COORD_MAX, COORD_MIN, '0);
      send_point(fx(0.0), fx(0.0));
      send_point(COORD_MAX, COORD_MIN);

      // start value at the extremes escapes at once
      configure(1'b0, COORD_MAX, COORD_MIN, count_type'(1));
      send_point(fx(0.0), fx(0.0));

      // largest limit with two points that never escape and one that does
      configure(1'b0, fx(0.0), fx(0.0), COUNT_MAX);
      send_point(fx(0.0), fx(0.0));
      send_point(fx(-1.0), fx(0.0));
      send_point(fx(0.5), fx(0.0));

      // random settings, random points, with and without sender gaps
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode_pick = 1'($urandom_range(0, 1));
         cre_pick  = (!mode_pick && $urandom_range(0, 1) == 0) ? fx(0.0) : rand_const();
         case ($urandom_range(0, 3))
            0:       limit_pick = count_type'($urandom_range(1, 8));
            1:       limit_pick = count_type'(LIMIT_RESET);
            default: limit_pick = count_type'($urandom_range(9, 255));
         endcase
         configure(mode_pick, cre_pick,
                   (!mode_pick && cre_pick == 0) ? fx(0.0) : rand_const(), limit_pick);
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_POINTS; n++)
            send_point(rand_coord(), rand_coord());
      end

      // let stray results show up before the verdict
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
